[rtl/core/cpdc_pkg.sv]
// ----------------------------------------------------------------------------
// cpdc_pkg
// Shared constants, the scan state carried along the step pipeline, and the
// elaboration-time inverse of a power of three.
// ----------------------------------------------------------------------------
package cpdc_pkg;

   // fixed field widths of the ports
   localparam int RES_W  = 28;
   localparam int CODE_W = 5;

   // step count range
   localparam int DEPTH_DEFAULT = 28;
   localparam int DEPTH_MAX     = 32;

   // step index holds 0..DEPTH_MAX, height holds -DEPTH_MAX..DEPTH_MAX
   localparam int IDX_W = $clog2(DEPTH_MAX + 1);
   localparam int HGT_W = IDX_W + 1;

   // reference pattern after reset
   localparam logic [RES_W-1:0] REF_RESET = 28'd115006171;

   // Newton iterations for an odd inverse modulo 2^32
   localparam int NEWTON_ITER = 6;

   // running classification of one item as it walks the steps
   typedef struct packed {
      logic                    mis_found;
      logic                    ret_found;
      logic                    later_found;
      logic                    immediate;
      logic [IDX_W-1:0]        mis_step;
      logic [IDX_W-1:0]        ret_step;
      logic [IDX_W-1:0]        later_step;
      logic [IDX_W-1:0]        ref_ones;
      logic signed [HGT_W-1:0] height;
   } scan_type;

   // inverse of 3^k modulo 2^32; only called with constant arguments
   function automatic logic [31:0] inv_pow3(input int k);
      logic [31:0] a;
      logic [31:0] x;
      a = 32'd1;
      x = 32'd1;
      for (int i = 0; i < k; i++) begin
         a = a * 32'd3;
      end
      for (int j = 0; j < NEWTON_ITER; j++) begin
         x = x * (32'd2 - a * x);
      end
      return x;
   endfunction

endpackage

[rtl/core/cpdc_step.sv]
// ----------------------------------------------------------------------------
// cpdc_step
// One shortened Collatz step plus one step of the parity scan, registered.
// ----------------------------------------------------------------------------
module cpdc_step
   import cpdc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int STEP  = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             ref_bit,
   input  logic             up_valid,
   output logic             up_ready,
   input  logic [DEPTH-1:0] up_value,
   input  logic [DEPTH-1:0] up_residue,
   input  scan_type         up_scan,
   output logic             dn_valid,
   input  logic             dn_ready,
   output logic [DEPTH-1:0] dn_value,
   output logic [DEPTH-1:0] dn_residue,
   output scan_type         dn_scan
);

   localparam logic [IDX_W-1:0] STEP_IDX = IDX_W'(STEP);

   logic                    valid_ff;
   logic [DEPTH-1:0]        value_ff;
   logic [DEPTH-1:0]        value_in;
   logic [DEPTH-1:0]        residue_ff;
   scan_type                scan_ff;
   scan_type                scan_in;
   logic                    parity;
   logic                    mismatch;
   logic signed [HGT_W-1:0] delta;
   logic signed [HGT_W-1:0] height_sum;
   logic                    load;

   assign parity   = up_value[0];
   assign mismatch = parity ^ ref_bit;

   // odd: (3x+1)/2 = x + (x>>1) + 1, even: x>>1; the top bit goes stale each step
   always_comb begin
      if (parity) begin
         value_in = up_value + (up_value >> 1) + DEPTH'(1);
      end else begin
         value_in = up_value >> 1;
      end
   end

   // actual minus reference parity
   always_comb begin
      if (parity && !ref_bit) begin
         delta = HGT_W'(signed'(2'sb01));
      end else if (!parity && ref_bit) begin
         delta = HGT_W'(signed'(2'sb11));
      end else begin
         delta = '0;
      end
   end

   assign height_sum = up_scan.height + delta;

   // advance the scan: first mismatch, then return to zero height, then later mismatch
   always_comb begin
      scan_in = up_scan;
      if (!up_scan.mis_found) begin
         if (mismatch) begin
            scan_in.mis_found = 1'b1;
            scan_in.mis_step  = STEP_IDX;
            scan_in.height    = delta;
         end else begin
            scan_in.ref_ones = up_scan.ref_ones + IDX_W'(ref_bit);
         end
      end else if (!up_scan.ret_found) begin
         scan_in.height = height_sum;
         if (height_sum == '0) begin
            scan_in.ret_found = 1'b1;
            scan_in.ret_step  = STEP_IDX;
            scan_in.immediate = (IDX_W'(up_scan.mis_step + IDX_W'(1)) == STEP_IDX);
         end
      end else if (!up_scan.later_found) begin
         if (mismatch) begin
            scan_in.later_found = 1'b1;
            scan_in.later_step  = STEP_IDX;
         end
      end
   end

   // take a new transfer when empty or when the next stage drains this one
   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         value_ff   <= value_in;
         residue_ff <= up_residue;
         scan_ff    <= scan_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_value   = value_ff;
   assign dn_residue = residue_ff;
   assign dn_scan    = scan_ff;

endmodule

[rtl/core/cpdc_translate.sv]
// ----------------------------------------------------------------------------
// cpdc_translate
// Two registered stages: look up the inverse power of three and shift it by
// the mismatch step, then subtract from the residue and form the result.
// ----------------------------------------------------------------------------
module cpdc_translate
   import cpdc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  logic [DEPTH-1:0]  up_residue,
   input  scan_type          up_scan,
   output logic              dn_valid,
   input  logic              dn_ready,
   output logic [CODE_W-1:0] dn_first_mismatch,
   output logic [CODE_W-1:0] dn_return_step,
   output logic [CODE_W-1:0] dn_later_mismatch,
   output logic              dn_immediate_return,
   output logic [RES_W-1:0]  dn_shifted_residue
);

   localparam int TAB_N  = DEPTH + 2;
   localparam int TAB_W  = $clog2(TAB_N);
   localparam int WIDE_W = (DEPTH > RES_W) ? DEPTH : RES_W;

   logic [DEPTH-1:0]  inv_tab [TAB_N];
   logic [IDX_W-1:0]  tab_sel;
   logic [DEPTH-1:0]  trans_in;

   logic              valid1_ff;
   logic [DEPTH-1:0]  trans_ff;
   logic [DEPTH-1:0]  residue_ff;
   scan_type          scan_ff;
   logic              load1;

   logic              valid2_ff;
   logic [CODE_W-1:0] first_ff;
   logic [CODE_W-1:0] ret_ff;
   logic [CODE_W-1:0] later_ff;
   logic              imm_ff;
   logic [RES_W-1:0]  shifted_ff;
   logic [RES_W-1:0]  shifted_in;
   logic [DEPTH-1:0]  diff;
   logic [WIDE_W-1:0] diff_wide;
   logic              load2;

   // constant table of 3^-k modulo 2^DEPTH
   for (genvar k = 0; k < TAB_N; k++) begin : g_inv
      localparam logic [31:0] INV_K = inv_pow3(k);
      assign inv_tab[k] = INV_K[DEPTH-1:0];
   end

   // exponent is the count of reference ones before the mismatch, plus one
   assign tab_sel  = IDX_W'(up_scan.ref_ones + IDX_W'(1));
   assign trans_in = inv_tab[tab_sel[TAB_W-1:0]] << up_scan.mis_step;

   // stage one: translation
   assign load1    = !valid1_ff || load2;
   assign up_ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (load1) begin
         valid1_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load1 && up_valid) begin
         trans_ff   <= trans_in;
         residue_ff <= up_residue;
         scan_ff    <= up_scan;
      end
   end

   // stage two: subtract, drop to the port width, zero unless the return is immediate
   assign diff      = residue_ff - trans_ff;
   assign diff_wide = WIDE_W'(diff);

   always_comb begin
      if (scan_ff.immediate) begin
         shifted_in = diff_wide[RES_W-1:0];
      end else begin
         shifted_in = '0;
      end
   end

   assign load2 = !valid2_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (load2) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load2 && valid1_ff) begin
         first_ff   <= scan_ff.mis_step[CODE_W-1:0];
         ret_ff     <= scan_ff.ret_step[CODE_W-1:0];
         later_ff   <= scan_ff.later_step[CODE_W-1:0];
         imm_ff     <= scan_ff.immediate;
         shifted_ff <= shifted_in;
      end
   end

   assign dn_valid            = valid2_ff;
   assign dn_first_mismatch   = first_ff;
   assign dn_return_step      = ret_ff;
   assign dn_later_mismatch   = later_ff;
   assign dn_immediate_return = imm_ff;
   assign dn_shifted_residue  = shifted_ff;

endmodule

[rtl/core/collatz_parity_defect_classifier.sv]
// ----------------------------------------------------------------------------
// collatz_parity_defect_classifier
// Classifies the Collatz parity vector of a residue against a reference
// pattern and reports mismatch, return and translated residue.
// ----------------------------------------------------------------------------
// One residue enters per cycle while the result side keeps taking results;
// results leave in the order the residues entered. Each of
// the DEPTH pipeline stages runs one shortened Collatz step and one step of
// the parity scan, and two more stages look up 3^-(q+1), shift it by the
// mismatch step and subtract it from the residue. Every stage has its own
// valid bit and fills while the output is held, so back-pressure on the
// result side stops input only once all stages are full. The reference
// pattern may only be written while the pipeline is empty.
module collatz_parity_defect_classifier
   import cpdc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [RES_W-1:0]  csr_reference_pattern,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [RES_W-1:0]  req_residue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_first_mismatch,
   output logic [CODE_W-1:0] rsp_return_step,
   output logic [CODE_W-1:0] rsp_later_mismatch,
   output logic              rsp_immediate_return,
   output logic [RES_W-1:0]  rsp_shifted_residue
);

   localparam int WIDE_W = (DEPTH > RES_W) ? DEPTH : RES_W;

   logic [RES_W-1:0]  ref_ff;
   logic [DEPTH-1:0]  ref_bits;
   logic [WIDE_W-1:0] residue_wide;
   scan_type          scan_init;

   logic              chain_valid   [DEPTH+1];
   logic              chain_ready   [DEPTH+1];
   logic [DEPTH-1:0]  chain_value   [DEPTH+1];
   logic [DEPTH-1:0]  chain_residue [DEPTH+1];
   scan_type          chain_scan    [DEPTH+1];

   // reference pattern register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_valid) begin
         ref_ff <= csr_reference_pattern;
      end
   end

   // reference bits beyond the register width read as zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_ref
      if (i < RES_W) begin : g_reg
         assign ref_bits[i] = ref_ff[i];
      end else begin : g_zero
         assign ref_bits[i] = 1'b0;
      end
   end

   // scan starts with nothing found; step codes start at "none"
   always_comb begin
      scan_init             = '0;
      scan_init.mis_step    = IDX_W'(DEPTH);
      scan_init.ret_step    = IDX_W'(DEPTH);
      scan_init.later_step  = IDX_W'(DEPTH);
   end

   assign residue_wide     = WIDE_W'(req_residue);
   assign chain_valid[0]   = req_valid;
   assign req_ready        = chain_ready[0];
   assign chain_value[0]   = residue_wide[DEPTH-1:0];
   assign chain_residue[0] = residue_wide[DEPTH-1:0];
   assign chain_scan[0]    = scan_init;

   // one stage per step
   for (genvar s = 0; s < DEPTH; s++) begin : g_step
      cpdc_step #(
         .DEPTH (DEPTH),
         .STEP  (s)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .ref_bit    (ref_bits[s]),
         .up_valid   (chain_valid[s]),
         .up_ready   (chain_ready[s]),
         .up_value   (chain_value[s]),
         .up_residue (chain_residue[s]),
         .up_scan    (chain_scan[s]),
         .dn_valid   (chain_valid[s+1]),
         .dn_ready   (chain_ready[s+1]),
         .dn_value   (chain_value[s+1]),
         .dn_residue (chain_residue[s+1]),
         .dn_scan    (chain_scan[s+1])
      );
   end

   // translation and result register
   cpdc_translate #(
      .DEPTH (DEPTH)
   ) u_translate (
      .clock               (clock),
      .reset               (reset),
      .up_valid            (chain_valid[DEPTH]),
      .up_ready            (chain_ready[DEPTH]),
      .up_residue          (chain_residue[DEPTH]),
      .up_scan             (chain_scan[DEPTH]),
      .dn_valid            (rsp_valid),
      .dn_ready            (rsp_ready),
      .dn_first_mismatch   (rsp_first_mismatch),
      .dn_return_step      (rsp_return_step),
      .dn_later_mismatch   (rsp_later_mismatch),
      .dn_immediate_return (rsp_immediate_return),
      .dn_shifted_residue  (rsp_shifted_residue)
   );

   // a return needs a mismatch before it
   a_ret_after_mis: assert property (@(posedge clock) disable iff (reset)
      chain_valid[DEPTH] && !chain_scan[DEPTH].mis_found |-> !chain_scan[DEPTH].ret_found)
      else $error("return found without a first mismatch");

   // later mismatch and immediate flag need a return
   a_later_after_ret: assert property (@(posedge clock) disable iff (reset)
      chain_valid[DEPTH] && !chain_scan[DEPTH].ret_found
      |-> !chain_scan[DEPTH].later_found && !chain_scan[DEPTH].immediate)
      else $error("later mismatch or immediate flag without a return");

   // immediate return sits one step after the mismatch
   a_imm_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_immediate_return
      |-> rsp_return_step == CODE_W'(rsp_first_mismatch + CODE_W'(1)))
      else $error("immediate return not one step after the mismatch");

   // translated residue is zero unless the return is immediate
   a_shift_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_immediate_return |-> rsp_shifted_residue == '0)
      else $error("shifted residue set without immediate return");

   // input stalls only when the held result backs up the whole pipeline
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output drains");

endmodule

[tb/tb_collatz_parity_defect_classifier.sv]
// ----------------------------------------------------------------------------
// tb_collatz_parity_defect_classifier
// Streams residues through the parity defect classifier under several
// reference patterns and compares every result with a local prediction.
// ----------------------------------------------------------------------------
// Most residues are forged so that their parity vector equals the reference
// pattern with a few chosen bits flipped. This steers the block into exact
// matches, level returns right after the first defect, later defects and
// walks that never return. The rest are plain random residues. Idling on
// both channels changes from phase to phase, and the pattern is rewritten
// only once the pipeline has drained.
module tb_collatz_parity_defect_classifier;
   import cpdc_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASES          = 6;

   typedef struct packed {
      logic [CODE_W-1:0] first_mismatch;
      logic [CODE_W-1:0] return_step;
      logic [CODE_W-1:0] later_mismatch;
      logic              immediate_return;
      logic [RES_W-1:0]  shifted_residue;
   } classification_type;

   typedef enum int {
      NOISE, LONE_FLIP, PAIR_FLIP, PAIR_THEN_FLIP, DEEP_TAIL, EXACT_MATCH
   } defect_kind_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // Predicts the classification of each accepted residue and checks results
   class defect_scoreboard;
      logic [RES_W-1:0]   pattern;
      classification_type awaited[$];
      int                 failures;
      int                 results;
      int                 immediates;
      int                 clean;

      function new();
         pattern    = REF_RESET;
         failures   = 0;
         results    = 0;
         immediates = 0;
         clean      = 0;
      endfunction

      function void set_pattern(logic [RES_W-1:0] value);
         pattern = value;
      endfunction

      // Parity seen at each shortened Collatz step
      function logic [DEPTH-1:0] parity_vector(logic [RES_W-1:0] residue);
         logic [63:0]      x;
         logic [DEPTH-1:0] v;
         x = 64'(residue);
         for (int i = 0; i < DEPTH; i++) begin
            v[i] = x[0];
            x = x[0] ? (64'd3 * x + 64'd1) >> 1 : x >> 1;
         end
         return v;
      endfunction

      function classification_type classify(logic [RES_W-1:0] residue);
         logic [DEPTH-1:0]   parity;
         logic [31:0]        power;
         logic [31:0]        inverse;
         logic [RES_W-1:0]   offset;
         int                 p;
         int                 ret;
         int                 later;
         int                 height;
         int                 ones;
         classification_type c;
         parity = parity_vector(residue);
         p      = DEPTH;
         ret    = DEPTH;
         later  = DEPTH;
         height = 0;
         ones   = 0;
         // find the first step that departs from the pattern
         for (int i = 0; i < DEPTH; i++)
            if (p == DEPTH && parity[i] != pattern[i]) p = i;
         // walk the relative height until it is level again
         for (int i = p; i < DEPTH; i++)
            if (ret == DEPTH) begin
               height += int'(parity[i]) - int'(pattern[i]);
               if (i > p && height == 0) ret = i;
            end
         // next departure after the return
         if (ret < DEPTH)
            for (int i = ret + 1; i < DEPTH; i++)
               if (later == DEPTH && parity[i] != pattern[i]) later = i;
         c.first_mismatch   = CODE_W'(p);
         c.return_step      = CODE_W'(ret);
         c.later_mismatch   = CODE_W'(later);
         c.immediate_return = (ret < DEPTH) && (ret == p + 1);
         c.shifted_residue  = '0;
         if (c.immediate_return) begin
            // subtract 2^p / 3^(q+1), q counting pattern ones below p
            for (int i = 0; i < p; i++) ones += int'(pattern[i]);
            power = 32'd1;
            for (int i = 0; i <= ones; i++) power = power * 32'd3;
            inverse = 32'd1;
            repeat (6) inverse = inverse * (32'd2 - power * inverse);
            offset = RES_W'(64'(inverse) << p);
            c.shifted_residue = residue - offset;
         end
         return c;
      endfunction

      function void note_residue(logic [RES_W-1:0] residue);
         awaited.push_back(classify(residue));
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(classification_type got);
         classification_type want;
         results++;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: first_mismatch %0d shifted_residue %0h",
                   got.first_mismatch, got.shifted_residue);
            failures++;
         end else begin
            want = awaited.pop_front();
            if (want.immediate_return) immediates++;
            if (want.first_mismatch == CODE_W'(DEPTH)) clean++;
            compare("first_mismatch", want.first_mismatch, got.first_mismatch);
            compare("return_step", want.return_step, got.return_step);
            compare("later_mismatch", want.later_mismatch, got.later_mismatch);
            compare("immediate_return", want.immediate_return, got.immediate_return);
            compare("shifted_residue", want.shifted_residue, got.shifted_residue);
         end
      endfunction
   endclass

   logic              clock                 = 1'b0;
   logic              reset                 = 1'b1;
   logic              csr_valid             = 1'b0;
   logic              csr_ready;
   logic [RES_W-1:0]  csr_reference_pattern = '0;
   logic              req_valid             = 1'b0;
   logic              req_ready;
   logic [RES_W-1:0]  req_residue           = '0;
   logic              rsp_valid;
   logic              rsp_ready             = 1'b0;
   logic [CODE_W-1:0] rsp_first_mismatch;
   logic [CODE_W-1:0] rsp_return_step;
   logic [CODE_W-1:0] rsp_later_mismatch;
   logic              rsp_immediate_return;
   logic [RES_W-1:0]  rsp_shifted_residue;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int sent           = 0;
   int patterns_used  = 1;

   defect_scoreboard sb = new();

   collatz_parity_defect_classifier uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_reference_pattern (csr_reference_pattern),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_residue           (req_residue),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_first_mismatch    (rsp_first_mismatch),
      .rsp_return_step       (rsp_return_step),
      .rsp_later_mismatch    (rsp_later_mismatch),
      .rsp_immediate_return  (rsp_immediate_return),
      .rsp_shifted_residue   (rsp_shifted_residue)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the result side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_first_mismatch, rsp_return_step, rsp_later_mismatch,
                          rsp_immediate_return, rsp_shifted_residue});
   end

   // Residue whose parity vector is the target: bit i flips step i parity and leaves earlier steps alone
   function automatic logic [RES_W-1:0] residue_with_parity(logic [DEPTH-1:0] target);
      logic [RES_W-1:0] r;
      logic [DEPTH-1:0] v;
      r = '0;
      for (int i = 0; i < DEPTH; i++) begin
         v = sb.parity_vector(r);
         if (v[i] != target[i]) r[i] = 1'b1;
      end
      return r;
   endfunction

   // Random residue, mostly forged as the pattern with chosen defects
   function automatic logic [RES_W-1:0] next_residue();
      defect_kind_type  kind;
      logic [RES_W-1:0] flips;
      int               a;
      kind = NOISE;
      if ($urandom_range(99) >= 30)
         kind = defect_kind_type'($urandom_range(int'(LONE_FLIP), int'(EXACT_MATCH)));
      a = $urandom_range(0, 24);
      case (kind)
         LONE_FLIP:      flips = RES_W'(1) << $urandom_range(0, DEPTH - 1);
         PAIR_FLIP:      flips = RES_W'(3) << $urandom_range(0, DEPTH - 2);
         PAIR_THEN_FLIP: flips = (RES_W'(3) << a)
                                 | (RES_W'(1) << $urandom_range(a + 2, DEPTH - 1));
         DEEP_TAIL:      flips = RES_W'($urandom) << $urandom_range(0, DEPTH - 1);
         EXACT_MATCH:    flips = '0;
         default:        flips = '0;
      endcase
      if (kind == NOISE) return RES_W'($urandom);
      return residue_with_parity(sb.pattern ^ flips);
   endfunction

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
         IDLE_BOTH:     begin send_idle_pct = 18; recv_stall_pct = 18; end
         default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Offer one residue and hold it until the transfer
   task automatic send_residue(logic [RES_W-1:0] residue);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_residue <= residue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_residue(residue);
      sent++;
   endtask

   task automatic send_forged(logic [RES_W-1:0] flips);
      send_residue(residue_with_parity(sb.pattern ^ flips));
   endtask

   // Drop the request and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_pattern(logic [RES_W-1:0] value);
      @(negedge clock);
      csr_valid             <= 1'b1;
      csr_reference_pattern <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_pattern(value);
      patterns_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and each outcome under the reset pattern
      set_idle(IDLE_NONE);
      send_residue('0);
      send_residue('1);
      send_residue(RES_W'(1));
      send_residue(RES_W'(1) << (RES_W - 1));
      send_residue({(RES_W/2){2'b01}});
      send_residue({(RES_W/2){2'b10}});
      send_forged('0);
      send_forged(RES_W'(1));
      send_forged(RES_W'(1) << (DEPTH - 1));
      send_forged(RES_W'(3));
      send_forged(RES_W'(3) << (DEPTH - 2));
      send_forged(RES_W'(3) << 5 | RES_W'(1) << 12);
      send_forged(RES_W'(3) << 10 | RES_W'(1) << (DEPTH - 1));
      send_forged(RES_W'(1) << 13);
      send_forged(RES_W'(6));
      send_forged(RES_W'(12) << 14);
      send_forged(~RES_W'(0) << 20);
      send_forged('1);
      drain();

      // random phases, each under its own pattern and an idling mode that cycles through the four
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       ;
            1:       write_pattern('0);
            2:       write_pattern('1);
            default: write_pattern(RES_W'($urandom));
         endcase
         set_idle(idle_mode_type'(ph % 4));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_residue(next_residue());
         drain();
      end

      // allow for stray results beyond the pipeline depth
      set_idle(IDLE_NONE);
      repeat (DEPTH + 8) @(posedge clock);
      if (sb.awaited.size() != 0) begin
         $error("%0d results never arrived", sb.awaited.size());
         sb.failures++;
      end
      $display("Classified %0d residues under %0d reference patterns with varied idling;",
               sent, patterns_used);
      $display("%0d exact pattern matches, %0d level returns right after the first defect.",
               sb.clean, sb.immediates);
      if (sb.failures == 0) begin
         $display("collatz_parity_defect_classifier: match");
      end else begin
         $display("collatz_parity_defect_classifier: mismatch");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #4000000;
      $display("collatz_parity_defect_classifier: mismatch");
      $finish;
   end

endmodule

[files.f]
rtl/core/cpdc_pkg.sv
rtl/core/cpdc_step.sv
rtl/core/cpdc_translate.sv
rtl/core/collatz_parity_defect_classifier.sv
tb/tb_collatz_parity_defect_classifier.sv
